// ----- src/bounded_positional_list_assert.svh -----
// Assertion macros for the bounded positional list checker
`ifndef BOUNDED_POSITIONAL_LIST_ASSERT_SVH
`define BOUNDED_POSITIONAL_LIST_ASSERT_SVH

// Check an implication on every clock edge outside reset
`define BPL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a next-cycle implication outside reset
`define BPL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/bpl_pkg.sv -----
// Shared constants and types of the bounded positional list
package bpl_pkg;
	localparam int CAPACITY  = 4096;
	localparam int ITEM_BITS = 8;
	localparam int SLOT_W    = $clog2(CAPACITY);
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int KIND_W    = 3;
	localparam int POS_W     = 13;
	localparam int STAT_W    = 2;

	typedef logic [SLOT_W-1:0]    slot_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [ITEM_BITS-1:0] item_t;

	typedef enum logic [KIND_W-1:0] {
		K_INS_FRONT = 3'd0,
		K_INS_BACK  = 3'd1,
		K_DEL_FRONT = 3'd2,
		K_DEL_BACK  = 3'd3,
		K_INS_AT    = 3'd4,
		K_DEL_AT    = 3'd5,
		K_READ_AT   = 3'd6,
		K_NONE      = 3'd7
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE    = 2'd0,
		ST_IGNORED = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	// Memory port command: read address plus optional write
	typedef struct packed {
		logic  we;
		slot_t waddr;
		item_t item_wd;
		slot_t next_wd;
		slot_t prev_wd;
		logic  we_item;
		logic  we_next;
		logic  we_prev;
		slot_t raddr;
	} node_cmd_t;

	typedef struct packed {
		item_t item;
		slot_t next;
		slot_t prev;
	} node_rd_t;
endpackage

// ----- src/bpl_if.sv -----
// Valid/ready channel interfaces for the bounded positional list
interface bpl_in_if;
	logic                          valid;
	logic                          ready;
	logic [bpl_pkg::KIND_W-1:0]    kind;
	logic [bpl_pkg::POS_W-1:0]     position;
	logic [bpl_pkg::ITEM_BITS-1:0] value;
	modport source (output valid, kind, position, value, input ready);
	modport sink (input valid, kind, position, value, output ready);
endinterface

interface bpl_out_if;
	logic                          valid;
	logic                          ready;
	logic [bpl_pkg::ITEM_BITS-1:0] read_value;
	logic [bpl_pkg::POS_W-1:0]     count;
	logic [bpl_pkg::STAT_W-1:0]    status;
	modport source (output valid, read_value, count, status, input ready);
	modport sink (input valid, read_value, count, status, output ready);
endinterface

// ----- src/bpl_node_mem.sv -----
// Node memory: item, next link and prev link per slot, registered read
module bpl_node_mem (
	input  logic               clk,
	input  bpl_pkg::node_cmd_t cmd,
	output bpl_pkg::node_rd_t  rd
);
	bpl_pkg::item_t item_mem [bpl_pkg::CAPACITY];
	bpl_pkg::slot_t next_mem [bpl_pkg::CAPACITY];
	bpl_pkg::slot_t prev_mem [bpl_pkg::CAPACITY];

	always_ff @(posedge clk) begin
		if (cmd.we && cmd.we_item) item_mem[cmd.waddr] <= cmd.item_wd;
		if (cmd.we && cmd.we_next) next_mem[cmd.waddr] <= cmd.next_wd;
		if (cmd.we && cmd.we_prev) prev_mem[cmd.waddr] <= cmd.prev_wd;
		rd.item <= item_mem[cmd.raddr];
		rd.next <= next_mem[cmd.raddr];
		rd.prev <= prev_mem[cmd.raddr];
	end
endmodule

// ----- src/bpl_free_mem.sv -----
// Free slot stack memory, registered read
module bpl_free_mem (
	input  logic           clk,
	input  logic           we,
	input  bpl_pkg::slot_t waddr,
	input  bpl_pkg::slot_t wdata,
	input  bpl_pkg::slot_t raddr,
	output bpl_pkg::slot_t rdata
);
	bpl_pkg::slot_t stack_mem [bpl_pkg::CAPACITY];

	always_ff @(posedge clk) begin
		if (we) stack_mem[waddr] <= wdata;
		rdata <= stack_mem[raddr];
	end
endmodule

// ----- src/bounded_positional_list.sv -----
// Bounded positional list: doubly linked slots held in synchronous memories
// Use: an operation enters on in (kind, position, value) with valid/ready; one
// result (read_value, count, status) leaves on out for every transfer.
// One operation is worked at a time by a sequencer around the node memory.
// Path of an accepted transfer: decode, then take (a slot for inserts);
//   ignored requests go straight to the result; front/back inserts link
//   the new node, waiting first when the slot comes from the free stack;
//   front/back deletes and inserts into a full list read the end node
//   first; positional accesses first walk from the nearer end, up to
//   (count - 1)/2 steps rounded down, with one memory read per step.
// The next transfer is accepted in the cycle after the result is loaded.
// The registered read of the node memory port sets the walk rate.
// Results sit in an output register; the next operation is accepted while an
// earlier result still waits, and the sequencer stalls only if a new result
// is ready before the old one is taken.
// Reset clears head, tail, count, free depth and the never-used mark; the
// memories need no clearing since only linked slots are read.
// A full list on any insert with a valid position drops the last item and reports full.
module bounded_positional_list (
	input logic clk,
	input logic arst_n,
	bpl_in_if.sink    in,
	bpl_out_if.source out
);
	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_TAKE, S_WALK_RD, S_WALK_WT, S_OP_RD, S_OP_WT,
		S_LINK1, S_LINK2, S_LINK3, S_FINISH
	} state_t;

	state_t             state_q;
	bpl_pkg::kind_t     kind_q;
	logic [bpl_pkg::POS_W-1:0] pos_q;
	bpl_pkg::item_t     value_q;
	bpl_pkg::cnt_t      count_q;
	bpl_pkg::slot_t     head_q, tail_q;
	bpl_pkg::cnt_t      free_depth_q, never_q;
	bpl_pkg::slot_t     cur_q, new_q, prev_q, next_q;
	bpl_pkg::cnt_t      steps_q;
	logic               walk_fwd_q;
	bpl_pkg::status_t   status_q;
	bpl_pkg::item_t     rd_q;
	// op codes chosen at decode
	typedef enum logic [2:0] {
		OP_PUSH_F, OP_PUSH_B, OP_POP_F, OP_POP_B, OP_PUT, OP_CUT, OP_READ, OP_NOP
	} op_t;
	op_t                op_q;
	logic               pend_q;
	logic               res_full_q;
	op_t                dec_op;
	bpl_pkg::status_t   dec_status;
	logic               finish_go;

	bpl_pkg::node_cmd_t cmd;
	bpl_pkg::node_rd_t  nrd;
	logic               fs_we;
	bpl_pkg::slot_t     fs_waddr, fs_wdata, fs_raddr, fs_rdata;

	bpl_node_mem u_node (.clk(clk), .cmd(cmd), .rd(nrd));
	bpl_free_mem u_free (.clk(clk), .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
		.raddr(fs_raddr), .rdata(fs_rdata));

	logic [bpl_pkg::POS_W:0] cnt_p1;
	logic                    full;
	assign cnt_p1 = {1'b0, count_q} + 14'd1;
	assign full   = count_q >= bpl_pkg::CNT_W'(bpl_pkg::CAPACITY);

	assign in.ready = (state_q == S_IDLE);
	assign out.valid = res_full_q;
	assign finish_go = (state_q == S_FINISH) && (!res_full_q || out.ready);

	bpl_pkg::slot_t fs_top;
	assign fs_top = bpl_pkg::SLOT_W'(free_depth_q - bpl_pkg::CNT_W'(1));

	// Pick the operation and its status from the held request
	always_comb begin
		dec_op     = OP_NOP;
		dec_status = bpl_pkg::ST_DONE;
		case (kind_q)
			bpl_pkg::K_INS_FRONT, bpl_pkg::K_INS_BACK: begin
				if (full) begin
					dec_op     = OP_POP_B;
					dec_status = bpl_pkg::ST_FULL;
				end else
					dec_op = (kind_q == bpl_pkg::K_INS_FRONT) ? OP_PUSH_F : OP_PUSH_B;
			end
			bpl_pkg::K_DEL_FRONT, bpl_pkg::K_DEL_BACK: begin
				if (count_q == '0) dec_status = bpl_pkg::ST_IGNORED;
				else dec_op = (kind_q == bpl_pkg::K_DEL_FRONT) ? OP_POP_F : OP_POP_B;
			end
			bpl_pkg::K_INS_AT: begin
				if ({1'b0, pos_q} > cnt_p1) dec_status = bpl_pkg::ST_IGNORED;
				else if (full) begin
					dec_op     = OP_POP_B;
					dec_status = bpl_pkg::ST_FULL;
				end else if (pos_q <= 13'd1) dec_op = OP_PUSH_F;
				else if ({1'b0, pos_q} == cnt_p1) dec_op = OP_PUSH_B;
				else dec_op = OP_PUT;
			end
			bpl_pkg::K_DEL_AT: begin
				if (pos_q == '0 || pos_q > count_q) dec_status = bpl_pkg::ST_IGNORED;
				else if (pos_q == 13'd1) dec_op = OP_POP_F;
				else if (pos_q == count_q) dec_op = OP_POP_B;
				else dec_op = OP_CUT;
			end
			bpl_pkg::K_READ_AT: begin
				if (pos_q == '0 || pos_q > count_q) dec_status = bpl_pkg::ST_IGNORED;
				else dec_op = OP_READ;
			end
			default: dec_status = bpl_pkg::ST_IGNORED;
		endcase
	end

	// Memory control
	always_comb begin
		cmd = '0;
		cmd.raddr = cur_q;
		fs_we = 1'b0;
		fs_waddr = free_depth_q[bpl_pkg::SLOT_W-1:0];
		fs_wdata = cur_q;
		fs_raddr = fs_top;
		case (state_q)
			S_LINK1: begin
				// hold writes until the slot from the free stack is in new_q
				cmd.we = !pend_q;
				cmd.waddr = new_q;
				cmd.item_wd = value_q;
				cmd.next_wd = next_q;
				cmd.prev_wd = prev_q;
				case (op_q)
					OP_PUSH_F: begin
						cmd.next_wd = head_q;
						cmd.we_item = 1'b1;
						cmd.we_next = (count_q != '0);
					end
					OP_PUSH_B: begin
						cmd.prev_wd = tail_q;
						cmd.we_item = 1'b1;
						cmd.we_prev = (count_q != '0);
					end
					OP_PUT: begin
						cmd.next_wd = cur_q;
						cmd.we_item = 1'b1;
						cmd.we_next = 1'b1;
						cmd.we_prev = 1'b1;
					end
					OP_CUT: begin
						cmd.waddr = prev_q;
						cmd.we_next = 1'b1;
					end
					default: cmd.we = 1'b0;
				endcase
			end
			S_LINK2: begin
				cmd.we = 1'b1;
				case (op_q)
					OP_PUSH_F: begin
						// count already advanced: link the old head unless the list was empty
						cmd.we = (count_q != bpl_pkg::CNT_W'(1));
						cmd.waddr = next_q;
						cmd.prev_wd = new_q;
						cmd.we_prev = 1'b1;
					end
					OP_PUSH_B: begin
						cmd.we = (count_q != bpl_pkg::CNT_W'(1));
						cmd.waddr = prev_q;
						cmd.next_wd = new_q;
						cmd.we_next = 1'b1;
					end
					OP_PUT: begin
						cmd.waddr = prev_q;
						cmd.next_wd = new_q;
						cmd.we_next = 1'b1;
					end
					OP_CUT: begin
						cmd.waddr = next_q;
						cmd.prev_wd = prev_q;
						cmd.we_prev = 1'b1;
					end
					default: cmd.we = 1'b0;
				endcase
			end
			S_LINK3: begin
				if (op_q == OP_PUT) begin
					cmd.we = 1'b1;
					cmd.waddr = cur_q;
					cmd.prev_wd = new_q;
					cmd.we_prev = 1'b1;
				end
				// return freed slot
				if ((op_q == OP_POP_F || op_q == OP_POP_B || op_q == OP_CUT)
						&& free_depth_q < bpl_pkg::CNT_W'(bpl_pkg::CAPACITY))
					fs_we = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			free_depth_q <= '0;
			never_q      <= '0;
			res_full_q   <= 1'b0;
			pend_q       <= 1'b0;
		end else begin
			if (finish_go) res_full_q <= 1'b1;
			else if (out.valid && out.ready) res_full_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in.valid) begin
						kind_q  <= bpl_pkg::kind_t'(in.kind);
						pos_q   <= in.position;
						value_q <= in.value;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					status_q <= dec_status;
					rd_q     <= '0;
					op_q     <= dec_op;
					state_q  <= S_TAKE;
					// set up walk from nearer end
					if (pos_q <= (count_q >> 1)) begin
						walk_fwd_q <= 1'b1;
						cur_q      <= head_q;
						steps_q    <= pos_q - bpl_pkg::CNT_W'(1);
					end else begin
						walk_fwd_q <= 1'b0;
						cur_q      <= tail_q;
						steps_q    <= count_q - pos_q;
					end
				end
				S_TAKE: begin
					// free stack read issued in this cycle (address fs_top)
					case (op_q)
						OP_PUSH_F, OP_PUSH_B, OP_PUT: begin
							if (free_depth_q != '0) begin
								free_depth_q <= free_depth_q - bpl_pkg::CNT_W'(1);
								pend_q <= 1'b1;
							end else begin
								new_q <= never_q[bpl_pkg::SLOT_W-1:0];
								if (never_q < bpl_pkg::CNT_W'(bpl_pkg::CAPACITY))
									never_q <= never_q + bpl_pkg::CNT_W'(1);
							end
						end
						default: ;
					endcase
					case (op_q)
						OP_PUSH_F, OP_PUSH_B: state_q <= S_LINK1;
						OP_POP_F: begin cur_q <= head_q; state_q <= S_OP_RD; end
						OP_POP_B: begin cur_q <= tail_q; state_q <= S_OP_RD; end
						OP_PUT, OP_CUT, OP_READ: state_q <= S_WALK_RD;
						default: state_q <= S_FINISH;
					endcase
				end
				S_WALK_RD: begin
					if (pend_q) begin
						new_q  <= fs_rdata;
						pend_q <= 1'b0;
					end
					if (steps_q == '0) state_q <= S_OP_RD;
					else state_q <= S_WALK_WT;
				end
				S_WALK_WT: begin
					cur_q   <= walk_fwd_q ? nrd.next : nrd.prev;
					steps_q <= steps_q - bpl_pkg::CNT_W'(1);
					state_q <= S_WALK_RD;
				end
				S_OP_RD: begin
					if (pend_q) begin
						new_q  <= fs_rdata;
						pend_q <= 1'b0;
					end
					state_q <= S_OP_WT;
				end
				S_OP_WT: begin
					prev_q <= nrd.prev;
					next_q <= nrd.next;
					if (op_q == OP_READ) rd_q <= nrd.item;
					state_q <= S_LINK1;
				end
				S_LINK1: begin
					if (pend_q) begin
						new_q  <= fs_rdata;
						pend_q <= 1'b0;
						state_q <= S_LINK1;
					end else begin
						case (op_q)
							OP_PUSH_F: begin
								next_q <= head_q;
								if (count_q == '0) tail_q <= new_q;
								head_q <= new_q;
								count_q <= count_q + bpl_pkg::CNT_W'(1);
							end
							OP_PUSH_B: begin
								prev_q <= tail_q;
								if (count_q == '0) head_q <= new_q;
								tail_q <= new_q;
								count_q <= count_q + bpl_pkg::CNT_W'(1);
							end
							OP_POP_F: begin
								if (count_q <= bpl_pkg::CNT_W'(1)) begin
									head_q <= '0; tail_q <= '0; count_q <= '0;
								end else begin
									head_q <= next_q;
									count_q <= count_q - bpl_pkg::CNT_W'(1);
								end
							end
							OP_POP_B: begin
								if (count_q <= bpl_pkg::CNT_W'(1)) begin
									head_q <= '0; tail_q <= '0; count_q <= '0;
								end else begin
									tail_q <= prev_q;
									count_q <= count_q - bpl_pkg::CNT_W'(1);
								end
							end
							OP_PUT, OP_CUT: count_q <= (op_q == OP_PUT)
								? count_q + bpl_pkg::CNT_W'(1) : count_q - bpl_pkg::CNT_W'(1);
							default: ;
						endcase
						state_q <= S_LINK2;
					end
				end
				S_LINK2: state_q <= S_LINK3;
				S_LINK3: begin
					if (fs_we) free_depth_q <= free_depth_q + bpl_pkg::CNT_W'(1);
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (finish_go) begin
						out.read_value <= rd_q;
						out.count <= count_q;
						out.status <= status_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- src/bpl_checker.sv -----
// Port-level checker for the bounded positional list, with its bind
`include "bounded_positional_list_assert.svh"
module bpl_port_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [bpl_pkg::POS_W-1:0]     out_count,
	input logic [bpl_pkg::STAT_W-1:0]    out_status,
	input logic [bpl_pkg::ITEM_BITS-1:0] out_read_value
);
	`BPL_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_count), "result dropped while stalled")
	`BPL_ASSERT_IMPL(a_count_cap, clk, arst_n, out_valid, out_count <= bpl_pkg::POS_W'(bpl_pkg::CAPACITY), "count above capacity")
	`BPL_ASSERT_IMPL(a_status_code, clk, arst_n, out_valid, out_status <= bpl_pkg::ST_FULL, "bad status")
	`BPL_ASSERT_IMPL(a_read_zero, clk, arst_n, out_valid && out_status != bpl_pkg::ST_DONE, out_read_value == '0, "read value on failed op")
	`BPL_ASSERT_NEXT(a_one_inflight, clk, arst_n, in_valid && in_ready, !in_ready, "second transfer accepted while busy")
endmodule

bind bounded_positional_list bpl_port_checker u_bpl_port_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in.valid), .in_ready(in.ready),
	.out_valid(out.valid), .out_ready(out.ready),
	.out_count(out.count), .out_status(out.status), .out_read_value(out.read_value)
);
